>>> rtl/bdrp_pkg.sv
// shared constants and types for the button debounce report port
`default_nettype none
package bdrp_pkg;

	localparam int NUM_BUTTONS   = 21;
	localparam int NUM_KNOBS     = 4;
	localparam int RAW_W         = 21;
	localparam int BTN_BYTES     = 3;
	localparam int BTN_BITS      = 8 * BTN_BYTES;
	localparam int REPORT_LEN    = BTN_BYTES + NUM_KNOBS;
	localparam int PTR_W         = $clog2(REPORT_LEN);
	localparam int KNOB_W        = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;
	localparam int KIDX_W        = 2;
	localparam logic [7:0] LOCKOUT_RESET = 8'd25;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_TICK = 2'd0;
	localparam mode_t MODE_READ = 2'd1;
	localparam mode_t MODE_KNOB = 2'd2;

	typedef struct packed {
		logic level_next;
		logic changed;
	} lane_stat_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       read_valid;
		logic       irq;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/button_debounce_report_port_top.sv
// top level: stream ports, lockout register, debouncer lanes and output skid
// the result of an item is registered in the output register, or in the skid register while the output is held
// throughput: one item per cycle while s_tready is high; the debouncer lanes and report merge are combinational
// an output register plus a skid register let a new item in while a result waits
// reset: asynchronous, active low; levels released, lockouts zero, report bytes 0xFF,
// knobs zero, pointer and interrupt zero, lockout_ticks 25
`default_nettype none
module button_debounce_report_port_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // raw_buttons[20:0], knob_index[22:21], knob_value[30:23]
	input  wire logic [1:0]  s_tuser,  // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // read_byte[7:0], irq_out[8]
	output logic             m_tuser,  // read_valid[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);
	import bdrp_pkg::*;

	logic [7:0]          lockout_q;
	logic                accept;
	logic                tick_en;
	logic [BTN_BITS-1:0] raw_ext;
	lane_stat_t          lanes [NUM_BUTTONS];
	result_t             res;
	result_t             out_q;
	result_t             skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign tick_en   = accept && (s_tuser == MODE_TICK);
	assign raw_ext   = BTN_BITS'(s_tdata[RAW_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lockout_q <= LOCKOUT_RESET;
		else if (cfg_valid && cfg_ready)
			lockout_q <= cfg_data;
	end

	genvar n;
	generate
		for (n = 0; n < NUM_BUTTONS; n++) begin : g_lane
			bdrp_lane u_lane (
				.clk           (clk),
				.arst_n        (arst_n),
				.tick_en       (tick_en),
				.raw_bit       (raw_ext[n]),
				.lockout_ticks (lockout_q),
				.stat          (lanes[n])
			);
		end
	endgenerate

	bdrp_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_en    (accept),
		.mode       (s_tuser),
		.knob_index (s_tdata[22:21]),
		.knob_value (s_tdata[30:23]),
		.lanes      (lanes),
		.res        (res)
	);

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.irq, out_q.read_byte};
	assign m_tuser  = out_q.read_valid;

endmodule
`default_nettype wire

>>> rtl/bdrp_lane.sv
// one button debouncer lane with lockout counter
`default_nettype none
module bdrp_lane (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tick_en,
	input  wire logic                 raw_bit,
	input  wire logic [7:0]           lockout_ticks,
	output bdrp_pkg::lane_stat_t      stat
);
	import bdrp_pkg::*;

	logic       level_q;
	logic [7:0] count_q;
	logic       free;

	assign free = (count_q == 8'd0);
	assign stat.changed = tick_en && free && (raw_bit != level_q);
	assign stat.level_next = stat.changed ? raw_bit : level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b1;
			count_q <= 8'd0;
		end else if (tick_en) begin
			if (free) begin
				if (raw_bit != level_q) begin
					level_q <= raw_bit;
					count_q <= lockout_ticks;
				end
			end else begin
				count_q <= count_q - 8'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/bdrp_report.sv
// merge stage: repacks lane levels, holds knobs, pointer and interrupt
`default_nettype none
module bdrp_report (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_en,
	input  wire bdrp_pkg::mode_t                  mode,
	input  wire logic [bdrp_pkg::KIDX_W-1:0]      knob_index,
	input  wire logic [7:0]                       knob_value,
	input  wire bdrp_pkg::lane_stat_t             lanes [bdrp_pkg::NUM_BUTTONS],
	output bdrp_pkg::result_t                     res
);
	import bdrp_pkg::*;

	logic [7:0]          btn_q  [BTN_BYTES];
	logic [7:0]          knob_q [NUM_KNOBS];
	logic [PTR_W-1:0]    ptr_q;
	logic                irq_q;
	logic [NUM_BUTTONS-1:0] chg_vec;
	logic [BTN_BITS-1:0] packed_lv;
	logic                any_change;
	logic [7:0]          rd_byte;

	genvar n;
	generate
		for (n = 0; n < BTN_BITS; n++) begin : g_pack
			if (n < NUM_BUTTONS) begin : g_used
				assign packed_lv[n] = lanes[n].level_next;
				assign chg_vec[n]   = lanes[n].changed;
			end else begin : g_unused
				assign packed_lv[n] = 1'b0;
			end
		end
	endgenerate

	assign any_change = |chg_vec;

	always_comb begin
		if (ptr_q < PTR_W'(BTN_BYTES))
			rd_byte = btn_q[2'(ptr_q)];
		else
			rd_byte = knob_q[KNOB_W'(ptr_q - PTR_W'(BTN_BYTES))];
	end

	always_comb begin
		res.read_byte  = 8'd0;
		res.read_valid = 1'b0;
		res.irq        = irq_q;
		unique case (mode)
			MODE_TICK: begin
				if (any_change)
					res.irq = 1'b1;
			end
			MODE_READ: begin
				res.read_byte  = rd_byte;
				res.read_valid = 1'b1;
				res.irq        = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BTN_BYTES; b++)
				btn_q[b] <= 8'hFF;
			for (int k = 0; k < NUM_KNOBS; k++)
				knob_q[k] <= 8'd0;
			ptr_q <= '0;
			irq_q <= 1'b0;
		end else if (item_en) begin
			irq_q <= res.irq;
			unique case (mode)
				MODE_TICK: begin
					if (any_change)
						for (int b = 0; b < BTN_BYTES; b++)
							btn_q[b] <= packed_lv[8*b +: 8];
				end
				MODE_READ: begin
					if (ptr_q == PTR_W'(REPORT_LEN - 1))
						ptr_q <= '0;
					else
						ptr_q <= ptr_q + PTR_W'(1);
				end
				MODE_KNOB: begin
					if (32'(knob_index) < NUM_KNOBS)
						knob_q[KNOB_W'(knob_index)] <= knob_value;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> tb/tb_button_debounce_report_port_top.sv
// testbench for button_debounce_report_port_top: directed table, then random items per lockout setting
`timescale 1ns / 100ps
module tb_button_debounce_report_port_top;
	import bdrp_pkg::*;

	localparam mode_t MODE_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 220;
	localparam int NUM_PHASES = 5;
	localparam int HOLD_AT_ITEM = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 4;
	localparam int PRINT_CAP = 100;

	localparam int RX_FREE = 0;
	localparam int RX_CHOPPY = 1;
	localparam int RX_STINGY = 2;

	typedef struct {
		mode_t            mode;
		logic [RAW_W-1:0] raw;
		logic [1:0]       kidx;
		logic [7:0]       kval;
	} stim_t;

	typedef struct {
		stim_t   item;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;

	// predictor state
	logic [NUM_BUTTONS-1:0] level_m;
	logic [7:0]             lock_left [NUM_BUTTONS];
	logic [BTN_BITS-1:0]    shown_bits;
	logic [7:0]             knob_m [NUM_KNOBS];
	logic [PTR_W-1:0]       read_ptr_m;
	logic                   irq_m;
	logic [7:0]             lockout_m;

	result_t          pending_answers [$];
	dir_row_t         dir_rows [$];
	logic [RAW_W-1:0] steady_raw;
	int               mismatches;
	int               items_sent;
	int               burst_left;
	int               cycle_count;
	int               phase_lockout [NUM_PHASES];
	result_t          seen;
	result_t          due;

	button_debounce_report_port_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t answer_for_item(input stim_t it);
		result_t r;
		logic    moved;
		r = '0;
		moved = 1'b0;
		case (it.mode)
			MODE_TICK: begin
				for (int n = 0; n < NUM_BUTTONS; n++) begin
					if (lock_left[n] == 8'd0) begin
						if (it.raw[n] != level_m[n]) begin
							level_m[n] = it.raw[n];
							lock_left[n] = lockout_m;
							moved = 1'b1;
						end
					end else begin
						lock_left[n] = lock_left[n] - 8'd1;
					end
				end
				if (moved) begin
					for (int n = 0; n < BTN_BITS; n++)
						shown_bits[n] = (n < NUM_BUTTONS) ? level_m[n] : 1'b0;
					irq_m = 1'b1;
				end
			end
			MODE_READ: begin
				irq_m = 1'b0;
				r.read_valid = 1'b1;
				if (read_ptr_m < BTN_BYTES)
					r.read_byte = shown_bits[read_ptr_m * 8 +: 8];
				else
					r.read_byte = knob_m[read_ptr_m - BTN_BYTES];
				read_ptr_m = (read_ptr_m == REPORT_LEN - 1) ? '0 : read_ptr_m + 1'b1;
			end
			MODE_KNOB: begin
				if (it.kidx < NUM_KNOBS)
					knob_m[it.kidx] = it.kval;
			end
			default: begin
			end
		endcase
		r.irq = irq_m;
		return r;
	endfunction

	// ticks follow a slowly changing held pattern with some contact bounce
	function automatic stim_t next_random_item();
		stim_t it;
		int    pick;
		pick = $urandom_range(0, 99);
		it.raw = RAW_W'($urandom);
		it.kidx = 2'($urandom);
		it.kval = 8'($urandom);
		if (pick < 58) begin
			it.mode = MODE_TICK;
			if ($urandom_range(0, 3) == 0)
				for (int k = $urandom_range(1, 3); k > 0; k--)
					steady_raw[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
			if ($urandom_range(0, 19) != 0) begin
				it.raw = steady_raw;
				if ($urandom_range(0, 2) == 0)
					it.raw ^= RAW_W'($urandom & $urandom & $urandom);
			end
		end else if (pick < 83) begin
			it.mode = MODE_READ;
		end else if (pick < 97) begin
			it.mode = MODE_KNOB;
		end else begin
			it.mode = MODE_SPARE;
		end
		return it;
	endfunction

	task automatic add_row(input mode_t mode, input logic [RAW_W-1:0] raw,
			input logic [1:0] kidx, input logic [7:0] kval, input bit typed,
			input logic [7:0] rbyte, input logic rvalid, input logic irq);
		dir_row_t row;
		row.item.mode = mode;
		row.item.raw = raw;
		row.item.kidx = kidx;
		row.item.kval = kval;
		row.typed = typed;
		row.want.read_byte = rbyte;
		row.want.read_valid = rvalid;
		row.want.irq = irq;
		dir_rows.push_back(row);
	endtask

	task automatic send_item(input stim_t it, input bit typed, input result_t want);
		int      gap;
		result_t answer;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, it.kval, it.kidx, it.raw};
		s_tuser <= it.mode;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		answer = answer_for_item(it);
		pending_answers.push_back(typed ? want : answer);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_lockout(input logic [7:0] ticks);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		lockout_m = ticks;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < PRINT_CAP)
			$display("mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// receiver
	initial begin
		int hold_left;
		int stretch_left;
		int stretch_kind;
		bit hold_done;
		m_tready = 1'b0;
		hold_left = 0;
		stretch_left = 0;
		stretch_kind = RX_FREE;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					stretch_kind = $urandom_range(RX_FREE, RX_STINGY);
					stretch_left = $urandom_range(4, 50);
				end
				stretch_left--;
				case (stretch_kind)
					RX_FREE: m_tready <= 1'b1;
					RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			seen.read_byte = m_tdata[7:0];
			seen.irq = m_tdata[8];
			seen.read_valid = m_tuser;
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected item", m_tdata, 0);
			end else begin
				due = pending_answers.pop_front();
				if (seen.read_byte !== due.read_byte)
					report_mismatch("read_byte", seen.read_byte, due.read_byte);
				if (seen.read_valid !== due.read_valid)
					report_mismatch("read_valid", seen.read_valid, due.read_valid);
				if (seen.irq !== due.irq)
					report_mismatch("irq_out", seen.irq, due.irq);
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("button_debounce_report_port_top test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_TICK;
		cfg_valid = 1'b0;
		cfg_data = '0;
		level_m = '1;
		shown_bits = '1;
		read_ptr_m = '0;
		irq_m = 1'b0;
		lockout_m = LOCKOUT_RESET;
		foreach (lock_left[n]) lock_left[n] = 8'd0;
		foreach (knob_m[k]) knob_m[k] = 8'd0;
		steady_raw = '1;
		mismatches = 0;
		items_sent = 0;
		burst_left = 0;

		// report right after reset, pointer wrap, knobs, unused mode, first change
		add_row(MODE_READ, '0, 2'd0, 8'h00, 1, 8'hFF, 1'b1, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 1, 8'hFF, 1'b1, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 1, 8'hFF, 1'b1, 1'b0);
		add_row(MODE_READ, '1, 2'd3, 8'hFF, 1, 8'h00, 1'b1, 1'b0);
		add_row(MODE_KNOB, '1, 2'd0, 8'hFF, 1, 8'h00, 1'b0, 1'b0);
		add_row(MODE_KNOB, '0, 2'd1, 8'h00, 1, 8'h00, 1'b0, 1'b0);
		add_row(MODE_KNOB, '0, 2'd2, 8'hA5, 1, 8'h00, 1'b0, 1'b0);
		add_row(MODE_KNOB, '0, 2'd3, 8'h5A, 1, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 1, 8'hFF, 1'b1, 1'b0);
		add_row(MODE_SPARE, '1, 2'd3, 8'hFF, 1, 8'h00, 1'b0, 1'b0);
		add_row(MODE_TICK, '1, 2'd0, 8'h00, 1, 8'h00, 1'b0, 1'b0);
		add_row(MODE_TICK, '0, 2'd3, 8'hFF, 1, 8'h00, 1'b0, 1'b1);
		add_row(MODE_TICK, '1, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_SPARE, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_TICK, 21'h155555, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);
		add_row(MODE_READ, '0, 2'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0);

		phase_lockout[0] = 1;
		phase_lockout[1] = 255;
		phase_lockout[2] = 3;
		phase_lockout[3] = $urandom_range(2, 254);
		phase_lockout[4] = 1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_lockout(8'(phase_lockout[p]));
			repeat (PHASE_ITEMS) send_item(next_random_item(), 1'b0, '0);
		end
		settle();

		if (mismatches == 0)
			$display("button_debounce_report_port_top test passed");
		else
			$display("button_debounce_report_port_top test failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/bdrp_pkg.sv
rtl/bdrp_lane.sv
rtl/bdrp_report.sv
rtl/button_debounce_report_port_top.sv
tb/tb_button_debounce_report_port_top.sv
